// ===== design/aeprq_pkg.sv =====
// shared types and constants of the active/expired priority run queue
`timescale 1ns / 1ps
`default_nettype none

package aeprq_pkg;

    localparam int LEVELS_DEF   = 4;
    localparam int SLOTS_DEF    = 16;
    localparam int ID_COUNT_DEF = 256;

    localparam int DYN_W  = 2;
    localparam int STAT_W = 3;

    // priority drop applied to a preempted task
    localparam logic [DYN_W-1:0] PREEMPT = 2'd1;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctl_cmd;

endpackage

`default_nettype wire

// ===== design/aeprq_ctrl.sv =====
// controller: item sequencing and result handshake
`timescale 1ns / 1ps
`default_nettype none

module aeprq_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output aeprq_pkg::t_ctl_cmd   o_cmd
);

    aeprq_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aeprq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = aeprq_pkg::ST_EXEC;
            end
            aeprq_pkg::ST_EXEC: begin
                if (w_out_free) n_state = aeprq_pkg::ST_IDLE;
            end
            default: n_state = aeprq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            aeprq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            aeprq_pkg::ST_EXEC: begin
                o_cmd.exec = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aeprq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/aeprq_datapath.sv =====
// datapath: fifo pointers, id memory, level select and result registers
`timescale 1ns / 1ps
`default_nettype none

module aeprq_datapath #(
    parameter int LEVELS   = aeprq_pkg::LEVELS_DEF,
    parameter int SLOTS    = aeprq_pkg::SLOTS_DEF,
    parameter int ID_COUNT = aeprq_pkg::ID_COUNT_DEF,
    localparam int ID_W    = $clog2(ID_COUNT),
    localparam int LW      = $clog2(LEVELS)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  aeprq_pkg::t_ctl_cmd          i_cmd,
    input  wire                          i_op,
    input  wire  [ID_W-1:0]              i_task_id,
    input  wire  [aeprq_pkg::DYN_W-1:0]  i_dyn_prio,
    input  wire  [aeprq_pkg::STAT_W-1:0] i_static_prio,
    input  wire                          i_was_preempted,
    output logic [ID_W-1:0]              o_out_id,
    output logic                         o_found,
    output logic [LW-1:0]                o_out_prio,
    output logic                         o_to_expired,
    output logic                         o_dropped
);

    localparam int QUEUES = 2 * LEVELS;
    localparam int QW     = $clog2(QUEUES);
    localparam int DEPTH  = QUEUES * SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 1;

    localparam int DYN_W  = aeprq_pkg::DYN_W;
    localparam int STAT_W = aeprq_pkg::STAT_W;

    // captured item
    aeprq_pkg::t_op    r_op;
    logic [ID_W-1:0]   r_id;
    logic [DYN_W-1:0]  r_dyn;
    logic [STAT_W-1:0] r_stat;
    logic              r_pre;

    logic [SLOT_W-1:0] r_head  [QUEUES];
    logic [CNT_W-1:0]  r_count [QUEUES];
    logic              r_bank;
    logic [ID_W-1:0]   mem [DEPTH];

    logic [ID_W-1:0]   r_rd_id;
    logic              r_found, r_exp, r_drop;
    logic [LW-1:0]     r_prio;

    logic [LEVELS-1:0] w_ne0, w_ne1, w_ne_sel;
    logic              w_any, w_take_bank, w_take_hit;
    logic [LW-1:0]     w_take_lvl;

    logic              w_add_exp, w_add_bank, w_add_full;
    logic [LW-1:0]     w_add_lvl;
    logic [DYN_W-1:0]  w_dyn_new;
    logic [STAT_W-1:0] w_stat_m1;

    logic              w_bank;
    logic [LW-1:0]     w_lvl;
    logic [QW-1:0]     w_q;
    logic [SLOT_W-1:0] w_head;
    logic [CNT_W-1:0]  w_count;
    logic [SUM_W-1:0]  w_sum;
    logic [SLOT_W-1:0] w_tail, w_slot, w_head_nx;
    logic [AW-1:0]     w_addr;
    logic              w_wr_en, w_rd_en;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= aeprq_pkg::t_op'(i_op);
            r_id   <= i_task_id;
            r_dyn  <= i_dyn_prio;
            r_stat <= i_static_prio;
            r_pre  <= i_was_preempted;
        end
    end

    // non-empty flags per bank
    always_comb begin
        for (int lv = 0; lv < LEVELS; lv++) begin
            w_ne0[lv] = (r_count[lv] != '0);
            w_ne1[lv] = (r_count[LEVELS + lv] != '0);
        end
    end

    assign w_any       = r_bank ? |w_ne1 : |w_ne0;
    assign w_take_bank = w_any ? r_bank : !r_bank;
    assign w_ne_sel    = w_take_bank ? w_ne1 : w_ne0;

    always_comb begin
        w_take_hit = 1'b0;
        w_take_lvl = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (w_ne_sel[lv]) begin
                w_take_hit = 1'b1;
                w_take_lvl = LW'(lv);
            end
        end
    end

    // add: preempt drop and level clamp
    assign w_add_exp  = r_pre && (r_dyn == '0);
    assign w_dyn_new  = r_pre ? (r_dyn - aeprq_pkg::PREEMPT) : r_dyn;
    assign w_stat_m1  = (r_stat == '0) ? '0 : (r_stat - STAT_W'(1));
    assign w_add_bank = w_add_exp ? !r_bank : r_bank;

    always_comb begin
        if (w_add_exp) begin
            if (int'(w_stat_m1) > LEVELS - 1) w_add_lvl = LW'(LEVELS - 1);
            else w_add_lvl = LW'(w_stat_m1);
        end else begin
            if (int'(w_dyn_new) > LEVELS - 1) w_add_lvl = LW'(LEVELS - 1);
            else w_add_lvl = LW'(w_dyn_new);
        end
    end

    // shared queue select
    assign w_bank  = (r_op == aeprq_pkg::OP_TAKE) ? w_take_bank : w_add_bank;
    assign w_lvl   = (r_op == aeprq_pkg::OP_TAKE) ? w_take_lvl : w_add_lvl;
    assign w_q     = (w_bank ? QW'(LEVELS) : QW'(0)) + QW'(w_lvl);
    assign w_head  = r_head[w_q];
    assign w_count = r_count[w_q];

    assign w_add_full = (w_count == CNT_W'(SLOTS));
    assign w_sum      = SUM_W'(w_head) + SUM_W'(w_count);
    assign w_tail     = (w_sum >= SUM_W'(SLOTS)) ? SLOT_W'(w_sum - SUM_W'(SLOTS))
                                                 : SLOT_W'(w_sum);
    assign w_head_nx  = (w_head == SLOT_W'(SLOTS - 1)) ? '0 : (w_head + SLOT_W'(1));
    assign w_slot     = (r_op == aeprq_pkg::OP_TAKE) ? w_head : w_tail;
    assign w_addr     = AW'(w_q) * AW'(SLOTS) + AW'(w_slot);

    assign w_wr_en = i_cmd.exec && (r_op == aeprq_pkg::OP_ADD) && !w_add_full;
    assign w_rd_en = i_cmd.exec && (r_op == aeprq_pkg::OP_TAKE) && w_take_hit;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_addr] <= r_id;
        if (w_rd_en) r_rd_id <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            for (int k = 0; k < QUEUES; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (r_op == aeprq_pkg::OP_TAKE) begin
                r_bank <= w_take_bank;
                if (w_take_hit) begin
                    r_head[w_q]  <= w_head_nx;
                    r_count[w_q] <= w_count - CNT_W'(1);
                end
            end else if (!w_add_full) begin
                r_count[w_q] <= w_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == aeprq_pkg::OP_TAKE) begin
                r_found <= w_take_hit;
                r_prio  <= w_take_hit ? w_take_lvl : '0;
                r_exp   <= 1'b0;
                r_drop  <= 1'b0;
            end else begin
                r_found <= 1'b0;
                r_prio  <= w_add_lvl;
                r_exp   <= w_add_exp;
                r_drop  <= w_add_full;
            end
        end
    end

    assign o_out_id     = r_found ? r_rd_id : '0;
    assign o_found      = r_found;
    assign o_out_prio   = r_prio;
    assign o_to_expired = r_exp;
    assign o_dropped    = r_drop;

endmodule

`default_nettype wire

// ===== design/active_expired_priority_run_queue.sv =====
// top level of the active/expired priority run queue
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | op, task_id, dyn_prio, static_prio,
//          |           |                             | was_preempted
//  out     | output    | o_out_valid / i_out_ready   | out_id, found, out_prio, to_expired,
//          |           |                             | dropped
//
//  each item is first registered, then the pointer update and the
//  single-port id memory access run, whose registered read data is the result
//  a result waits in the output register while the next item is taken in
//  a stalled output holds the execute step until the result register frees
//  synchronous active-low reset clears the pointers, counts and bank select;
//  the id memory is not cleared, the fill counts guard its reads
`timescale 1ns / 1ps
`default_nettype none

module active_expired_priority_run_queue #(
    parameter int LEVELS   = aeprq_pkg::LEVELS_DEF,
    parameter int SLOTS    = aeprq_pkg::SLOTS_DEF,
    parameter int ID_COUNT = aeprq_pkg::ID_COUNT_DEF,
    localparam int ID_W    = $clog2(ID_COUNT),
    localparam int LW      = $clog2(LEVELS)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_op,
    input  wire  [ID_W-1:0]              i_task_id,
    input  wire  [aeprq_pkg::DYN_W-1:0]  i_dyn_prio,
    input  wire  [aeprq_pkg::STAT_W-1:0] i_static_prio,
    input  wire                          i_was_preempted,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [ID_W-1:0]              o_out_id,
    output logic                         o_found,
    output logic [LW-1:0]                o_out_prio,
    output logic                         o_to_expired,
    output logic                         o_dropped
);

    aeprq_pkg::t_ctl_cmd w_cmd;

    aeprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    aeprq_datapath #(
        .LEVELS   (LEVELS),
        .SLOTS    (SLOTS),
        .ID_COUNT (ID_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_op            (i_op),
        .i_task_id       (i_task_id),
        .i_dyn_prio      (i_dyn_prio),
        .i_static_prio   (i_static_prio),
        .i_was_preempted (i_was_preempted),
        .o_out_id        (o_out_id),
        .o_found         (o_found),
        .o_out_prio      (o_out_prio),
        .o_to_expired    (o_to_expired),
        .o_dropped       (o_dropped)
    );

endmodule

`default_nettype wire

// ===== design/aeprq_checker.sv =====
// port-level checker for the run queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module aeprq_checker #(
    parameter int ID_W = 8,
    parameter int LW   = 2
) (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_ready,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input wire [ID_W-1:0] o_out_id,
    input wire            o_found,
    input wire [LW-1:0]   o_out_prio,
    input wire            o_to_expired,
    input wire            o_dropped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result valid dropped before accept");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while previous one still executing");

    a_take_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (!o_to_expired && !o_dropped))
        else $error("take result carries add flags");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found && !o_to_expired && !o_dropped && o_out_prio == '0)
            |-> (o_out_id == '0))
        else $error("empty result carries an id");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind active_expired_priority_run_queue aeprq_checker #(
    .ID_W ($clog2(ID_COUNT)),
    .LW   ($clog2(LEVELS))
) u_aeprq_checker (.*);

`default_nettype wire

// ===== tb/sv/active_expired_priority_run_queue_tb.sv =====
// self-checking testbench of the active/expired priority run queue
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] id;
    logic       found;
    logic [1:0] prio;
    logic       to_expired;
    logic       dropped;
} t_sched_result;

class run_queue_scoreboard;
    localparam int LEVELS = aeprq_pkg::LEVELS_DEF;
    localparam int SLOTS  = aeprq_pkg::SLOTS_DEF;

    logic [7:0]    id_store [2][LEVELS][SLOTS];
    int unsigned   head [2][LEVELS];
    int unsigned   fill [2][LEVELS];
    bit            active_bank;
    t_sched_result pending_results [$];
    int            errors;

    function new();
        for (int b = 0; b < 2; b++) begin
            for (int l = 0; l < LEVELS; l++) begin
                head[b][l] = 0;
                fill[b][l] = 0;
            end
        end
        active_bank = 1'b0;
        errors = 0;
    endfunction

    function int unsigned clamp_level(int p);
        if (p < 0) begin
            return 0;
        end
        if (p > LEVELS - 1) begin
            return LEVELS - 1;
        end
        return p;
    endfunction

    // predict the result of one accepted item and update the queue state
    function void note_item(aeprq_pkg::t_op op, logic [7:0] task_id, logic [1:0] dyn,
                            logic [2:0] stat, logic preempted);
        t_sched_result res;
        int            p;
        int unsigned   lvl;
        bit            bank;
        bit            any;
        res = '0;
        if (op == aeprq_pkg::OP_ADD) begin
            p = int'(dyn) - (preempted ? int'(aeprq_pkg::PREEMPT) : 0);
            if (p < 0) begin
                lvl = clamp_level(int'(stat) - 1);
                bank = ~active_bank;
                res.to_expired = 1'b1;
            end else begin
                lvl = clamp_level(p);
                bank = active_bank;
            end
            res.prio = lvl[1:0];
            if (fill[bank][lvl] >= SLOTS) begin
                res.dropped = 1'b1;
            end else begin
                id_store[bank][lvl][(head[bank][lvl] + fill[bank][lvl]) % SLOTS] = task_id;
                fill[bank][lvl]++;
            end
        end else begin
            any = 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                if (fill[active_bank][l] != 0) begin
                    any = 1'b1;
                end
            end
            if (!any) begin
                active_bank = ~active_bank;
            end
            for (int l = LEVELS - 1; l >= 0; l--) begin
                if (fill[active_bank][l] != 0) begin
                    res.id = id_store[active_bank][l][head[active_bank][l]];
                    res.found = 1'b1;
                    res.prio = l[1:0];
                    head[active_bank][l] = (head[active_bank][l] + 1) % SLOTS;
                    fill[active_bank][l]--;
                    break;
                end
            end
        end
        pending_results.insert(pending_results.size(), res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_sched_result got);
        t_sched_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %p", $time, got);
            errors++;
            return;
        end
        want = pending_results[0];
        pending_results.delete(0);
        compare_field("out_id", 32'(want.id), 32'(got.id));
        compare_field("found", 32'(want.found), 32'(got.found));
        compare_field("out_prio", 32'(want.prio), 32'(got.prio));
        compare_field("to_expired", 32'(want.to_expired), 32'(got.to_expired));
        compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module active_expired_priority_run_queue_tb;

    localparam int RANDOM_ITEMS = 1600;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_op = 1'b0;
    logic [7:0] i_task_id = '0;
    logic [1:0] i_dyn_prio = '0;
    logic [2:0] i_static_prio = 3'd1;
    logic       i_was_preempted = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_id;
    logic       o_found;
    logic [1:0] o_out_prio;
    logic       o_to_expired;
    logic       o_dropped;

    run_queue_scoreboard sb = new();
    bit calm = 1'b0;
    int item_count = 0;

    active_expired_priority_run_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_task_id       (i_task_id),
        .i_dyn_prio      (i_dyn_prio),
        .i_static_prio   (i_static_prio),
        .i_was_preempted (i_was_preempted),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_id        (o_out_id),
        .o_found         (o_found),
        .o_out_prio      (o_out_prio),
        .o_to_expired    (o_to_expired),
        .o_dropped       (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic send_item(aeprq_pkg::t_op op, logic [7:0] task_id, logic [1:0] dyn,
                             logic [2:0] stat, logic preempted, int gap);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_task_id <= task_id;
        i_dyn_prio <= dyn;
        i_static_prio <= stat;
        i_was_preempted <= preempted;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_item(op, task_id, dyn, stat, preempted);
        item_count++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int add_pct, bit flood, logic [1:0] f_dyn, logic [2:0] f_stat,
                               logic f_pre);
        logic [2:0] stat;
        if ($urandom_range(0, 99) >= add_pct) begin
            send_item(aeprq_pkg::OP_TAKE, 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), next_gap());
        end else if (flood) begin
            send_item(aeprq_pkg::OP_ADD, 8'($urandom_range(0, 255)), f_dyn, f_stat, f_pre,
                      next_gap());
        end else begin
            stat = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
            send_item(aeprq_pkg::OP_ADD, 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)), stat, 1'($urandom_range(0, 1)), next_gap());
        end
    endtask

    // result sink with random back-pressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result('{o_out_id, o_found, o_out_prio, o_to_expired, o_dropped});
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = next_gap();
            end
        end
    end

    initial begin
        int kind;
        int seg_len;
        int add_pct;
        bit flood;
        logic [1:0] f_dyn;
        logic [2:0] f_stat;
        logic f_pre;
        int drain_wait;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both banks empty
        send_item(aeprq_pkg::OP_TAKE, 8'h00, 2'd0, 3'd0, 1'b0, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'h00, 2'd0, 3'd1, 1'b0, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'hff, 2'd3, 3'd4, 1'b0, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'ha5, 2'd3, 3'd2, 1'b1, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'h5a, 2'd0, 3'd4, 1'b1, next_gap());
        // static priority zero and above the top level, then takes that drain both banks
        send_item(aeprq_pkg::OP_ADD, 8'h11, 2'd0, 3'd0, 1'b1, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'h22, 2'd0, 3'd7, 1'b1, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'h33, 2'd0, 3'd5, 1'b1, next_gap());
        send_item(aeprq_pkg::OP_ADD, 8'h44, 2'd1, 3'd6, 1'b1, next_gap());
        repeat (9) send_item(aeprq_pkg::OP_TAKE, 8'hff, 2'd3, 3'd7, 1'b1, next_gap());

        while (item_count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            calm = ($urandom_range(0, 4) == 0);
            flood = 1'b0;
            f_dyn = 2'($urandom_range(0, 3));
            f_stat = 3'($urandom_range(1, 4));
            f_pre = 1'($urandom_range(0, 1));
            seg_len = $urandom_range(10, 60);
            case (kind)
                0, 1, 2, 3: add_pct = 50;
                4, 5: add_pct = 85;
                6, 7: add_pct = 20;
                8: begin
                    add_pct = 100;
                    flood = 1'b1;
                    seg_len = $urandom_range(18, 24);
                end
                default: begin
                    add_pct = 0;
                    seg_len = $urandom_range(20, 50);
                end
            endcase
            repeat (seg_len) send_random(add_pct, flood, f_dyn, f_stat, f_pre);
        end
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end

        drain_wait = 0;
        while (sb.pending() != 0 && drain_wait < 10000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending() != 0) begin
                $display("%0t: results missing, expected %0d more actual 0", $time,
                         sb.pending());
            end
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== active_expired_priority_run_queue.f =====
design/aeprq_pkg.sv
design/aeprq_ctrl.sv
design/aeprq_datapath.sv
design/active_expired_priority_run_queue.sv
design/aeprq_checker.sv
tb/sv/active_expired_priority_run_queue_tb.sv
